// ===== rtl/tmtw_pkg.sv =====
// Shared types and codes of the text-mode terminal writer.
package tmtw_pkg;

    localparam int CURSOR_W    = 11;
    localparam int INDEX_W     = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 1'b1;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;

    typedef struct packed {
        logic                command;
        logic [7:0]          char_code;
        logic                last_in_string;
        logic [INDEX_W-1:0]  cell_index;
    } item_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_position;
        logic                cursor_update;
        logic [7:0]          read_char;
        logic [7:0]          read_attribute;
        logic                scrolled;
    } result_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic sweep;
        logic clear_mode;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic grow;
        logic more;
        logic sweep_last;
    } ctrl_stat_t;

endpackage

// ===== rtl/tmtw_ctrl.sv =====
// Controller state machine of the text-mode terminal writer.
module tmtw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output tmtw_pkg::ctrl_cmd_t   cmd,
    input  tmtw_pkg::ctrl_stat_t  stat
);
    import tmtw_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_EXEC   = 4'b0100,
        S_SCROLL = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep      = 1'b1;
                cmd.clear_mode = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.grow)
                begin
                    state_next = S_SCROLL;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCROLL:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last && !stat.more)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg == S_EXEC))
        else $error("accepted item did not enter execution");

    a_single_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> !cmd.emit)
        else $error("result emitted on two adjacent cycles");

    a_sweep_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCROLL && !stat.sweep_last) |=> (state_reg == S_SCROLL))
        else $error("scroll sweep left before its last cell");

endmodule

// ===== rtl/tmtw_dpath.sv =====
// Datapath of the text-mode terminal writer: cursor, screen store and result register.
module tmtw_dpath #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tmtw_pkg::item_t       item,
    input  logic [7:0]            attr,
    input  tmtw_pkg::ctrl_cmd_t   cmd,
    output tmtw_pkg::ctrl_stat_t  stat,
    output tmtw_pkg::result_t     result,
    output logic                  done
);
    import tmtw_pkg::*;

    localparam int CELL_COUNT   = ROWS * COLUMNS;
    localparam int SCROLL_LIMIT = (ROWS - 1) * COLUMNS;
    localparam int AW  = $clog2(CELL_COUNT);
    localparam int SW  = $clog2(CELL_COUNT + 1);
    localparam int SAW = $clog2(CELL_COUNT + COLUMNS + 1);
    localparam int CW  = $clog2((ROWS + 2) * COLUMNS);
    localparam int RW  = $clog2(ROWS + 2);
    localparam int CLW = $clog2(COLUMNS);
    localparam int CXW = $clog2(COLUMNS + TAB_STOP);
    localparam int DW  = $clog2(TAB_STOP + 1);
    localparam int IXW = (SW > INDEX_W) ? SW : INDEX_W;
    localparam int POW = (CW > CURSOR_W) ? CW : CURSOR_W;
    localparam logic [CW-1:0] RECIP = CW'((2 ** CW) / TAB_STOP);

    item_t              item_reg;
    logic               rd_ok_reg;
    logic [CW-1:0]      cur_reg;
    logic [CW-1:0]      cur_next;
    logic [RW-1:0]      row_reg;
    logic [RW-1:0]      row_next;
    logic [CLW-1:0]     col_reg;
    logic [CLW-1:0]     col_next;
    logic               scr_reg;
    logic               scr_next;
    logic [2*CW-1:0]    prod_reg;
    logic [SW-1:0]      swp_reg;
    logic [SW-1:0]      swp_next;
    logic [15:0]        mem [CELL_COUNT];
    logic [15:0]        rdata_reg;
    result_t            res_reg;
    result_t            res_next;
    logic               done_reg;

    logic [CW-1:0]      quot;
    logic [CW-1:0]      quot_t;
    logic [CW-1:0]      rem0;
    logic [CW-1:0]      rem;
    logic [DW-1:0]      tab_d;
    logic [CW-1:0]      exec_cur;
    logic [RW-1:0]      exec_row;
    logic [CLW-1:0]     exec_col;
    logic               is_put;
    logic               put_write;
    logic               swp_last;
    logic               scroll_end;
    logic [SAW-1:0]     swp_ra;
    logic [SW-1:0]      swp_wa;
    logic [IXW-1:0]     idx_ext;
    logic               idx_ok;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [AW-1:0]      mem_ra;
    logic [15:0]        mem_wd;
    logic [POW-1:0]     pos_ext;

    // Position within the tab stop: quotient by reciprocal, one correction step.
    assign quot   = prod_reg[2*CW-1:CW];
    assign quot_t = quot * CW'(TAB_STOP);
    assign rem0   = cur_reg - quot_t;
    assign rem    = (rem0 >= CW'(TAB_STOP)) ? (rem0 - CW'(TAB_STOP)) : rem0;
    assign tab_d  = DW'(TAB_STOP) - DW'(rem);

    assign is_put = (item_reg.command == CMD_PUT);

    always_comb
    begin
        logic [DW-1:0]  step;
        logic [CXW-1:0] cx;
        logic [RW-1:0]  rx;
        step = (item_reg.char_code == CH_TAB) ? tab_d : DW'(1);
        cx   = CXW'(col_reg) + CXW'(step);
        rx   = row_reg;
        if (cx >= CXW'(COLUMNS))
        begin
            cx = cx - CXW'(COLUMNS);
            rx = rx + RW'(1);
        end
        if (cx >= CXW'(COLUMNS))
        begin
            cx = cx - CXW'(COLUMNS);
            rx = rx + RW'(1);
        end
        exec_cur = cur_reg + CW'(step);
        exec_row = rx;
        exec_col = CLW'(cx);
        unique case (item_reg.char_code)
            CH_NEWLINE:
            begin
                exec_cur = cur_reg - CW'(col_reg) + CW'(COLUMNS);
                exec_row = row_reg + RW'(1);
                exec_col = '0;
            end
            CH_RETURN:
            begin
                exec_cur = cur_reg - CW'(col_reg);
                exec_row = row_reg;
                exec_col = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign put_write = cmd.exec && is_put && (item_reg.char_code != CH_TAB)
                       && (item_reg.char_code != CH_NEWLINE)
                       && (item_reg.char_code != CH_RETURN);

    // Sweep: read one row ahead, write the cell behind with last cycle's data.
    assign swp_last   = (swp_reg == SW'(CELL_COUNT));
    assign scroll_end = cmd.sweep && !cmd.clear_mode && swp_last;
    assign swp_next   = cmd.sweep ? (swp_last ? '0 : swp_reg + SW'(1)) : swp_reg;
    assign swp_ra     = SAW'(swp_reg) + SAW'(COLUMNS);
    assign swp_wa     = swp_reg - SW'(1);

    assign idx_ext = IXW'(item.cell_index);
    assign idx_ok  = (idx_ext < IXW'(CELL_COUNT));

    always_comb
    begin
        if (cmd.sweep)
        begin
            mem_ra = (swp_ra < SAW'(CELL_COUNT)) ? AW'(swp_ra) : '0;
            mem_we = (swp_reg != '0);
            mem_wa = AW'(swp_wa);
            mem_wd = (!cmd.clear_mode && swp_wa < SW'(SCROLL_LIMIT)) ? rdata_reg : '0;
        end
        else
        begin
            mem_ra = idx_ok ? idx_ext[AW-1:0] : '0;
            mem_we = put_write;
            mem_wa = AW'(cur_reg);
            mem_wd = {attr, item_reg.char_code};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[mem_ra];
    end

    always_comb
    begin
        cur_next = cur_reg;
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.exec && is_put)
        begin
            cur_next = exec_cur;
            row_next = exec_row;
            col_next = exec_col;
        end
        else if (scroll_end)
        begin
            cur_next = cur_reg - CW'(COLUMNS);
            row_next = row_reg - RW'(1);
        end
        scr_next = cmd.load ? 1'b0 : (scroll_end ? 1'b1 : scr_reg);
    end

    assign stat.grow       = is_put && (exec_row >= RW'(ROWS));
    assign stat.more       = (row_reg > RW'(ROWS));
    assign stat.sweep_last = swp_last;

    assign pos_ext = POW'(cur_next);

    always_comb
    begin
        res_next.cursor_position = pos_ext[CURSOR_W-1:0];
        res_next.cursor_update   = is_put && item_reg.last_in_string;
        res_next.read_char       = (!is_put && rd_ok_reg) ? rdata_reg[7:0] : '0;
        res_next.read_attribute  = (!is_put && rd_ok_reg) ? rdata_reg[15:8] : '0;
        res_next.scrolled        = scr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            scr_reg  <= 1'b0;
            swp_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cur_reg  <= cur_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            scr_reg  <= scr_next;
            swp_reg  <= swp_next;
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= (2*CW)'(cur_reg) * (2*CW)'(RECIP);
        if (cmd.load)
        begin
            item_reg  <= item;
            rd_ok_reg <= idx_ok;
        end
        if (cmd.emit)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;
    assign done   = done_reg;

    a_cursor_coherent: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg == CW'(row_reg * COLUMNS + col_reg))
        else $error("linear cursor disagrees with row and column");

    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (row_reg < RW'(ROWS)))
        else $error("result delivered with cursor below the last row");

    a_read_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && item_reg.command == CMD_READ)
            |-> (!res_reg.scrolled && !res_reg.cursor_update))
        else $error("read result carries put flags");

endmodule

// ===== rtl/text_mode_terminal_writer.sv =====
// Top level of the text-mode terminal writer: configuration registers and unit wiring.
//
// Usage:
//  - Input: drive item and raise start; the item transfers at a clock edge where
//    start is high and busy is low. A put writes a character or applies newline,
//    carriage return or tab; a read fetches one screen cell.
//  - Result: every item gives exactly one result, shown on result for one cycle
//    with done high. The receiver cannot stall it, so take it when done is high.
//  - Sequence: a put that does not scroll and every read pass from the transfer
//    cycle to an execute cycle; done rises in the cycle after that, while a new item
//    may already transfer. A new item is taken only once the last has executed.
//  - Scrolling: each row scrolled adds a sweep of the whole cell store, paced by
//    the single write port of the cell store that moves one cell per cycle.
//  - Reset: the cursor goes to cell 0, foreground to 7, background to 0, and a
//    clearing pass zeroes the store with busy held high.
//  - Configuration: cfg_wr_en with cfg_index (0 foreground, 1 background) and
//    cfg_data writes a colour register at once; write only while idle.
module text_mode_terminal_writer #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  tmtw_pkg::item_t                     item,
    output logic                                done,
    output tmtw_pkg::result_t                   result,
    input  logic                                cfg_wr_en,
    input  logic [tmtw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tmtw_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tmtw_pkg::*;

    logic [CFG_DATA_W-1:0] fg_reg;
    logic [CFG_DATA_W-1:0] bg_reg;
    logic [7:0]            attr;
    ctrl_cmd_t             cmd;
    ctrl_stat_t            stat;

    // Colour registers: take the write at once, no handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= 4'd7;
            bg_reg <= 4'd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FOREGROUND: fg_reg <= cfg_data;
                REG_BACKGROUND: bg_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Attribute byte: background in the high nibble, foreground in the low.
    assign attr = {bg_reg, fg_reg};

    tmtw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    tmtw_dpath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .attr   (attr),
        .cmd    (cmd),
        .stat   (stat),
        .result (result),
        .done   (done)
    );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the text-mode terminal writer.
`timescale 1ns / 1ps

module tb;
    import tmtw_pkg::*;

    // Screen geometry, matched to the instance below.
    localparam int COLS      = 80;
    localparam int ROWS      = 25;
    localparam int TAB_STOP  = 8;
    localparam int CELLS     = ROWS * COLS;
    localparam int ITEM_GOAL = 450;

    // One queued action for the driver: an item transfer or a colour register write.
    typedef struct {
        bit                     is_cfg;
        item_t                  it;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  value;
    } pending_op_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    item_t                  item_in = '0;
    logic                   done;
    result_t                result;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index_r = '0;
    logic [CFG_DATA_W-1:0]  cfg_data_r = '0;

    pending_op_t  pending_ops[$];
    result_t      awaited_results[$];
    int           mismatch_count = 0;
    int           queued_items = 0;
    logic         took = 1'b0;
    int           gap_left = 0;
    int           burst_left = 0;

    // Shadow copy of the screen, the cursor and the colour registers.
    logic [15:0]           shadow_cells [0:CELLS-1];
    int unsigned           shadow_cursor = 0;
    logic [CFG_DATA_W-1:0] shadow_fg = 4'd7;
    logic [CFG_DATA_W-1:0] shadow_bg = 4'd0;

    text_mode_terminal_writer #(
        .COLUMNS  (COLS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item_in),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index_r),
        .cfg_data  (cfg_data_r)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    // Apply one item to the shadow screen and return the result it should give.
    function automatic result_t screen_step(input item_t it);
        result_t r;
        int      k;
        r = '0;
        if (it.command == CMD_READ)
        begin
            // Cells beyond the screen read as zero.
            if (it.cell_index < CELLS)
            begin
                r.read_char      = shadow_cells[it.cell_index][7:0];
                r.read_attribute = shadow_cells[it.cell_index][15:8];
            end
        end
        else
        begin
            case (it.char_code)
                CH_NEWLINE: shadow_cursor = (shadow_cursor + COLS) / COLS * COLS;
                CH_RETURN:  shadow_cursor = shadow_cursor / COLS * COLS;
                CH_TAB:     shadow_cursor = (shadow_cursor + TAB_STOP) / TAB_STOP * TAB_STOP;
                default:
                begin
                    if (shadow_cursor < CELLS)
                        shadow_cells[shadow_cursor] = {shadow_bg, shadow_fg, it.char_code};
                    shadow_cursor++;
                end
            endcase
            // Scroll once per row the cursor has run past the bottom.
            while (shadow_cursor / COLS > ROWS - 1)
            begin
                for (k = 0; k < (ROWS - 1) * COLS; k++)
                    shadow_cells[k] = shadow_cells[k + COLS];
                for (k = (ROWS - 1) * COLS; k < CELLS; k++)
                    shadow_cells[k] = '0;
                shadow_cursor -= COLS;
                r.scrolled = 1'b1;
            end
            r.cursor_update = it.last_in_string;
        end
        r.cursor_position = shadow_cursor[CURSOR_W-1:0];
        return r;
    endfunction

    task automatic add_put(input logic [7:0] ch, input logic last);
        pending_op_t op;
        op.is_cfg            = 1'b0;
        op.it.command        = CMD_PUT;
        op.it.char_code      = ch;
        op.it.last_in_string = last;
        // The index means nothing to a put; fill it with noise.
        op.it.cell_index     = INDEX_W'($urandom_range(0, 2047));
        op.reg_idx           = '0;
        op.value             = '0;
        pending_ops.push_back(op);
        queued_items++;
    endtask

    task automatic add_read(input int idx, input logic last);
        pending_op_t op;
        op.is_cfg            = 1'b0;
        op.it.command        = CMD_READ;
        op.it.char_code      = 8'($urandom_range(0, 255));
        op.it.last_in_string = last;
        op.it.cell_index     = INDEX_W'(idx);
        op.reg_idx           = '0;
        op.value             = '0;
        pending_ops.push_back(op);
        queued_items++;
    endtask

    task automatic add_cfg(input logic [CFG_INDEX_W-1:0] idx, input int val);
        pending_op_t op;
        op.is_cfg  = 1'b1;
        op.it      = '0;
        op.reg_idx = idx;
        op.value   = CFG_DATA_W'(val);
        pending_ops.push_back(op);
    endtask

    // Driver: change inputs on the falling edge, one assignment per signal per step.
    always @(negedge clk)
    begin : drive_proc
        logic                   nstart;
        item_t                  nitem;
        logic                   nwr;
        logic [CFG_INDEX_W-1:0] nidx;
        logic [CFG_DATA_W-1:0]  ndata;
        int                     r;
        nstart = start;
        nitem  = item_in;
        nwr    = 1'b0;
        nidx   = cfg_index_r;
        ndata  = cfg_data_r;
        // Hold an offered item until it transfers.
        if (rst_n && !(start && !took))
        begin
            nstart = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_ops.size() > 0)
            begin
                if (pending_ops[0].is_cfg)
                begin
                    // Write colours only once every result is back and the block is idle.
                    if (awaited_results.size() == 0 && !busy)
                    begin
                        nwr   = 1'b1;
                        nidx  = pending_ops[0].reg_idx;
                        ndata = pending_ops[0].value;
                        void'(pending_ops.pop_front());
                    end
                end
                else
                begin
                    nstart = 1'b1;
                    nitem  = pending_ops[0].it;
                    void'(pending_ops.pop_front());
                    if (burst_left > 0)
                        burst_left--;
                    // End of a burst: pick the next gap and burst length.
                    if (burst_left == 0)
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 40)
                            gap_left = 0;
                        else if (r < 85)
                            gap_left = $urandom_range(1, 4);
                        else
                            gap_left = $urandom_range(10, 40);
                        burst_left = $urandom_range(1, 30);
                    end
                end
            end
        end
        start       <= nstart;
        item_in     <= nitem;
        cfg_wr_en   <= nwr;
        cfg_index_r <= nidx;
        cfg_data_r  <= ndata;
    end

    // Monitor: sample on the rising edge, check results, then record new transfers.
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        result_t want;
        if (!rst_n)
            took <= 1'b0;
        else
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                    flag_mismatch("result arrived with nothing outstanding");
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.cursor_position !== want.cursor_position)
                        flag_mismatch($sformatf("cursor_position got %0d want %0d",
                                                result.cursor_position, want.cursor_position));
                    if (result.cursor_update !== want.cursor_update)
                        flag_mismatch($sformatf("cursor_update got %b want %b",
                                                result.cursor_update, want.cursor_update));
                    if (result.read_char !== want.read_char)
                        flag_mismatch($sformatf("read_char got %h want %h",
                                                result.read_char, want.read_char));
                    if (result.read_attribute !== want.read_attribute)
                        flag_mismatch($sformatf("read_attribute got %h want %h",
                                                result.read_attribute, want.read_attribute));
                    if (result.scrolled !== want.scrolled)
                        flag_mismatch($sformatf("scrolled got %b want %b",
                                                result.scrolled, want.scrolled));
                end
            end
            if (cfg_wr_en)
            begin
                if (cfg_index_r == REG_FOREGROUND)
                    shadow_fg = cfg_data_r;
                else if (cfg_index_r == REG_BACKGROUND)
                    shadow_bg = cfg_data_r;
            end
            took <= start && !busy;
            if (start && !busy)
                awaited_results.push_back(screen_step(item_in));
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin : stim_proc
        int kind;
        int n;
        int j;
        int r;
        int phase;
        int next_phase_at;
        logic [7:0] ch;

        foreach (shadow_cells[i])
            shadow_cells[i] = '0;

        // Directed part: reset colours first, out-of-range and marked reads,
        // extreme codes, every control character, then extreme colours.
        add_read(0, 1'b1);
        add_read(2047, 1'b0);
        add_read(CELLS, 1'b1);
        add_put(8'h41, 1'b0);
        add_put(8'hFF, 1'b0);
        add_put(8'h00, 1'b1);
        add_put(CH_TAB, 1'b0);
        add_put(CH_TAB, 1'b1);
        add_put(CH_RETURN, 1'b1);
        add_put(CH_NEWLINE, 1'b0);
        add_put(8'h7E, 1'b1);
        add_read(0, 1'b0);
        add_read(1, 1'b0);
        add_read(2, 1'b0);
        add_read(COLS, 1'b0);
        add_read(CELLS - 1, 1'b0);
        add_cfg(REG_FOREGROUND, 15);
        add_cfg(REG_BACKGROUND, 15);
        add_put(8'h20, 1'b0);
        add_read(COLS + 1, 1'b0);
        add_cfg(REG_FOREGROUND, 0);
        add_cfg(REG_BACKGROUND, 0);
        add_put(8'h80, 1'b1);
        add_read(COLS + 2, 1'b0);

        // Random part: strings of text, runs of newlines, long lines that wrap,
        // and bursts of reads, with the colours changed every so often.
        phase = 0;
        next_phase_at = queued_items + 80;
        while (queued_items < ITEM_GOAL)
        begin
            if (queued_items >= next_phase_at)
            begin
                case (phase % 4)
                    0:
                    begin
                        add_cfg(REG_FOREGROUND, 0);
                        add_cfg(REG_BACKGROUND, 15);
                    end
                    1:
                    begin
                        add_cfg(REG_FOREGROUND, 15);
                        add_cfg(REG_BACKGROUND, 0);
                    end
                    default:
                    begin
                        add_cfg(REG_FOREGROUND, $urandom_range(0, 15));
                        add_cfg(REG_BACKGROUND, $urandom_range(0, 15));
                    end
                endcase
                phase++;
                next_phase_at = queued_items + 80;
            end
            kind = $urandom_range(0, 99);
            if (kind < 25)
            begin
                n = $urandom_range(1, 4);
                for (j = 0; j < n; j++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 35)
                        add_read($urandom_range(CELLS - 2 * COLS, CELLS - 1), 1'($urandom));
                    else if (r < 65)
                        add_read($urandom_range(0, CELLS - 1), 1'($urandom));
                    else if (r < 80)
                        add_read($urandom_range(0, 2 * COLS - 1), 1'($urandom));
                    else if (r < 92)
                        add_read($urandom_range(CELLS, 2047), 1'($urandom));
                    else
                        add_read(($urandom_range(0, 1) == 0) ? 0 : CELLS - 1, 1'($urandom));
                end
            end
            else if (kind < 33)
            begin
                // Several newlines in a row: each one scrolls once the bottom is reached.
                n = $urandom_range(2, 6);
                for (j = 0; j < n; j++)
                    add_put(CH_NEWLINE, j == n - 1);
            end
            else if (kind < 42)
            begin
                // A line of 70 to 95 characters, so it can wrap (and scroll on the last row).
                n = $urandom_range(70, 95);
                for (j = 0; j < n; j++)
                begin
                    ch = ($urandom_range(0, 99) < 5) ? CH_TAB : 8'($urandom_range(32, 126));
                    add_put(ch, j == n - 1);
                end
            end
            else
            begin
                n = $urandom_range(1, 12);
                for (j = 0; j < n; j++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        ch = CH_NEWLINE;
                    else if (r < 20)
                        ch = CH_RETURN;
                    else if (r < 28)
                        ch = CH_TAB;
                    else
                        ch = 8'($urandom_range(0, 255));
                    add_put(ch, (j == n - 1) || ($urandom_range(0, 99) < 5));
                end
            end
        end

        // Hold reset, then release it on a falling edge, away from the rising edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every item to transfer and every result to come back.
        do
            @(posedge clk);
        while (pending_ops.size() != 0 || start || awaited_results.size() != 0 || busy);
        // Wait on for any stray result.
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond a run in which every put scrolls.
    initial
    begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tmtw_pkg.sv
rtl/tmtw_ctrl.sv
rtl/tmtw_dpath.sv
rtl/text_mode_terminal_writer.sv
test/tb.sv
